[hw/rtl/ipv4_receive_header_check_macros.svh]
// assertion macros for the ipv4 receive header check block
`ifndef IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH
`define IPV4_RECEIVE_HEADER_CHECK_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define IHC_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ihc assertion failed");
// next-cycle implication
`define IHC_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ihc assertion failed");
`else
`define IHC_ASSERT_NOW(label, ck, rs, ante, cons)
`define IHC_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif

`endif

[hw/rtl/ihc_pkg.sv]
// types, constants and codes shared by the header check modules
package ihc_pkg;

  localparam int unsigned IHC_QUEUE_DEPTH = 2;

  localparam int unsigned VERDICT_W   = 3;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS       = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERFACE_PRESENT = 1'b1;

  localparam logic [5:0]  MIN_HDR      = 6'd20;
  localparam logic [3:0]  IP_VERSION   = 4'd4;
  localparam logic [3:0]  NIBBLE_MASK  = 4'h0F;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  LOOPBACK_NET = 8'd127;
  localparam logic [31:0] BROADCAST    = 32'hFFFF_FFFF;
  localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_ICMP        = 3'd0,
    VERDICT_UDP         = 3'd1,
    VERDICT_OTHER       = 3'd2,
    VERDICT_TOO_SHORT   = 3'd3,
    VERDICT_BAD_HEADER  = 3'd4,
    VERDICT_BAD_SUM     = 3'd5,
    VERDICT_NOT_OURS    = 3'd6
  } ihc_verdict_t;

  typedef struct packed {
    logic [31:0] own_address;
    logic        interface_present;
  } ihc_cfg_t;

  // what the front captured for one packet
  typedef struct packed {
    logic [15:0] rx_len;
    logic [3:0]  version;
    logic [5:0]  hlen;
    logic [15:0] csum;
    logic [15:0] len_field;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } ihc_summary_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ihc_qstat_t;

endpackage

[hw/rtl/ihc_channels.sv]
// valid/ready channel interfaces for packet bytes and verdicts
interface ihc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;

  modport source(output valid, output pkt_byte, output last_byte, input ready);
  modport sink(input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface ihc_result_if import ihc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic [31:0]          source_address;
  logic [7:0]           time_to_live;
  logic [7:0]           protocol_number;
  logic [5:0]           header_bytes;
  logic [15:0]          payload_length;

  modport source(output valid, output verdict, output source_address,
                 output time_to_live, output protocol_number,
                 output header_bytes, output payload_length, input ready);
  modport sink(input valid, input verdict, input source_address,
               input time_to_live, input protocol_number,
               input header_bytes, input payload_length, output ready);
endinterface

[hw/rtl/ipv4_receive_header_check.sv]
// top level of the ipv4 receive header check block
// Takes one packet byte per clock on rx while rx.ready is high, with last_byte
// on the final byte, and gives one verdict item per packet on result, via the
// summary queue and the output register. The byte rate of one per cycle is set
// by the parser's per-byte count, capture and ones' complement add; up to
// QUEUE_DEPTH finished packet summaries wait between parser and verdict stage,
// plus one in the output register, before rx.ready drops. Drop verdicts carry
// zero in every other field. Write own_address and interface_present through
// cfg_we/cfg_index/cfg_data only while no packet is in flight (not enforced).
`include "ipv4_receive_header_check_macros.svh"

module ipv4_receive_header_check import ihc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = IHC_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  ihc_byte_if.sink               rx,
  ihc_result_if.source           result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  ihc_cfg_t     cfg;
  ihc_qstat_t   qstat;
  ihc_summary_t push_data;
  ihc_summary_t head;
  logic         push;
  logic         pop;
  logic         head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address       <= '0;
      cfg.interface_present <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:       cfg.own_address       <= cfg_data;
        CFG_INTERFACE_PRESENT: cfg.interface_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ihc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .qstat   (qstat),
    .push    (push),
    .summary (push_data)
  );

  ihc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .qstat      (qstat)
  );

  ihc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .result     (result)
  );

  // drop verdicts must not leak header fields
  `IHC_ASSERT_NOW(a_drop_zero, clk, rst, result.valid && result.verdict >= VERDICT_TOO_SHORT, result.source_address == 32'd0 && result.payload_length == 16'd0 && result.header_bytes == 6'd0)
  // an accepted packet always had a full-size header
  `IHC_ASSERT_NOW(a_accept_hlen, clk, rst, result.valid && result.verdict <= VERDICT_OTHER, result.header_bytes >= MIN_HDR)
  // the parser never writes into a full queue
  `IHC_ASSERT_NOW(a_no_overflow, clk, rst, push, !qstat.full)
  // a finished packet is waiting in the queue right after its last byte
  `IHC_ASSERT_NEXT(a_last_queued, clk, rst, rx.valid && rx.ready && rx.last_byte, !qstat.empty)

endmodule

[hw/rtl/ihc_front.sv]
// byte parser: counts bytes, captures header fields, sums header words
module ihc_front import ihc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ihc_byte_if.sink     rx,
  input  ihc_qstat_t   qstat,
  output logic         push,
  output ihc_summary_t summary
);

  logic [15:0] byte_count, byte_count_next;
  logic [3:0]  version_seen, version_seen_next;
  logic [5:0]  header_len_seen, header_len_seen_next;
  logic [15:0] sum_accumulator, sum_accumulator_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [15:0] total_len_seen, total_len_seen_next;
  logic [7:0]  ttl_seen, ttl_seen_next;
  logic [7:0]  proto_seen, proto_seen_next;
  logic [31:0] src_seen, src_seen_next;
  logic [31:0] dst_seen, dst_seen_next;

  logic        accept;
  logic        in_hdr;
  logic [7:0]  b;

  function automatic logic [15:0] oc_add(input logic [15:0] x, input logic [15:0] y);
    logic [16:0] s;
    s = {1'b0, x} + {1'b0, y};
    // one fold is enough: the folded value cannot carry again
    return s[15:0] + {15'd0, s[16]};
  endfunction

  assign b        = rx.pkt_byte;
  assign rx.ready = !qstat.full;
  assign accept   = rx.valid && rx.ready;
  assign push     = accept && rx.last_byte;

  always_comb begin
    version_seen_next    = version_seen;
    header_len_seen_next = header_len_seen;
    total_len_seen_next  = total_len_seen;
    ttl_seen_next        = ttl_seen;
    proto_seen_next      = proto_seen;
    src_seen_next        = src_seen;
    dst_seen_next        = dst_seen;
    high_byte_hold_next  = high_byte_hold;
    sum_accumulator_next = sum_accumulator;

    case (byte_count)
      16'd0: begin
        version_seen_next    = b[7:4];
        header_len_seen_next = {b[3:0] & NIBBLE_MASK, 2'b00};
      end
      16'd2: total_len_seen_next = {b, total_len_seen[7:0]};
      16'd3: total_len_seen_next = {total_len_seen[15:8], b};
      16'd8: ttl_seen_next = b;
      16'd9: proto_seen_next = b;
      default: begin
      end
    endcase
    if (byte_count >= 16'd12 && byte_count <= 16'd15) begin
      src_seen_next = {src_seen[23:0], b};
    end
    if (byte_count >= 16'd16 && byte_count <= 16'd19) begin
      dst_seen_next = {dst_seen[23:0], b};
    end

    // header length of byte zero applies to byte zero itself
    in_hdr = byte_count < {10'd0, header_len_seen_next};
    if (in_hdr) begin
      if (!byte_count[0]) begin
        high_byte_hold_next = b;
      end else begin
        sum_accumulator_next = oc_add(sum_accumulator, {high_byte_hold, b});
      end
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_comb begin
    summary.rx_len    = byte_count_next;
    summary.version   = version_seen_next;
    summary.hlen      = header_len_seen_next;
    summary.csum      = sum_accumulator_next;
    summary.len_field = total_len_seen_next;
    summary.ttl       = ttl_seen_next;
    summary.proto     = proto_seen_next;
    summary.src       = src_seen_next;
    summary.dst       = dst_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      byte_count      <= '0;
      version_seen    <= '0;
      header_len_seen <= '0;
      sum_accumulator <= '0;
      high_byte_hold  <= '0;
      total_len_seen  <= '0;
      ttl_seen        <= '0;
      proto_seen      <= '0;
      src_seen        <= '0;
      dst_seen        <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      version_seen    <= version_seen_next;
      header_len_seen <= header_len_seen_next;
      sum_accumulator <= sum_accumulator_next;
      high_byte_hold  <= high_byte_hold_next;
      total_len_seen  <= total_len_seen_next;
      ttl_seen        <= ttl_seen_next;
      proto_seen      <= proto_seen_next;
      src_seen        <= src_seen_next;
      dst_seen        <= dst_seen_next;
    end
  end

endmodule

[hw/rtl/ihc_queue.sv]
// short queue of packet summaries between parser and verdict stage
module ihc_queue import ihc_pkg::*; #(
  parameter int unsigned DEPTH = IHC_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ihc_summary_t push_data,
  input  logic         pop,
  output ihc_summary_t head,
  output logic         head_valid,
  output ihc_qstat_t   qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ihc_summary_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/ihc_back.sv]
// verdict stage: checks a packet summary and registers the result item
module ihc_back import ihc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ihc_cfg_t     cfg,
  input  ihc_summary_t head,
  input  logic         head_valid,
  output logic         pop,
  ihc_result_if.source result
);

  ihc_verdict_t verdict, verdict_reg;
  logic        out_valid;
  logic        dst_ok;
  logic        accepted;
  logic [15:0] hlen16;
  logic [15:0] tl;
  logic [15:0] payload;
  logic [31:0] src_reg;
  logic [7:0]  ttl_reg;
  logic [7:0]  proto_reg;
  logic [5:0]  hlen_reg;
  logic [15:0] payload_reg;

  assign hlen16 = {10'd0, head.hlen};

  always_comb begin
    dst_ok = !cfg.interface_present || head.dst == cfg.own_address ||
             head.dst == BROADCAST || head.dst[31:24] == LOOPBACK_NET;

    if (head.rx_len < {10'd0, MIN_HDR}) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (head.version != IP_VERSION || head.hlen < MIN_HDR ||
                 head.rx_len < hlen16) begin
      verdict = VERDICT_BAD_HEADER;
    end else if (head.csum != SUM_GOOD) begin
      verdict = VERDICT_BAD_SUM;
    end else if (!dst_ok) begin
      verdict = VERDICT_NOT_OURS;
    end else if (head.proto == PROTO_ICMP) begin
      verdict = VERDICT_ICMP;
    end else if (head.proto == PROTO_UDP) begin
      verdict = VERDICT_UDP;
    end else begin
      verdict = VERDICT_OTHER;
    end

    accepted = (verdict == VERDICT_ICMP) || (verdict == VERDICT_UDP) ||
               (verdict == VERDICT_OTHER);

    // clamp to what arrived, then floor the payload at zero
    tl      = (head.len_field > head.rx_len) ? head.rx_len : head.len_field;
    payload = (tl > hlen16) ? tl - hlen16 : 16'd0;
  end

  assign pop = head_valid && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_reg <= verdict;
      src_reg     <= accepted ? head.src : 32'd0;
      ttl_reg     <= accepted ? head.ttl : 8'd0;
      proto_reg   <= accepted ? head.proto : 8'd0;
      hlen_reg    <= accepted ? head.hlen : 6'd0;
      payload_reg <= accepted ? payload : 16'd0;
    end
  end

  assign result.valid           = out_valid;
  assign result.verdict         = verdict_reg;
  assign result.source_address  = src_reg;
  assign result.time_to_live    = ttl_reg;
  assign result.protocol_number = proto_reg;
  assign result.header_bytes    = hlen_reg;
  assign result.payload_length  = payload_reg;

endmodule

[verif/ipv4_receive_header_check_tb.sv]
// testbench for the ipv4 receive header check: directed and random packets against a predictor
module ipv4_receive_header_check_tb import ihc_pkg::*; ();

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned DRAIN_TAIL    = 20;
  localparam int unsigned CHUNK_BYTES   = 200;
  localparam int unsigned RANDOM_BUDGET = 310;

  typedef struct packed {
    ihc_verdict_t verdict;
    logic [31:0]  src;
    logic [7:0]   ttl;
    logic [7:0]   proto;
    logic [5:0]   hbytes;
    logic [15:0]  plen;
  } verdict_item_t;

  typedef struct {
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] tot;
    bit          auto_len;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } header_spec_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ihc_byte_if   rx_ch ();
  ihc_result_if res_ch ();

  ipv4_receive_header_check dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  int unsigned   src_idle_pct;
  int unsigned   sink_idle_pct;
  int unsigned   mismatches;
  int unsigned   bytes_sent;
  verdict_item_t verdict_expected[$];

  // predictor copy of configuration and per-packet state
  logic [31:0] own_addr_q;
  logic        filter_on_q;
  logic [15:0] rx_count;
  logic [3:0]  hdr_version;
  logic [5:0]  hdr_len;
  logic [15:0] csum_acc;
  logic [7:0]  hi_hold;
  logic [15:0] tot_len;
  logic [7:0]  hdr_ttl;
  logic [7:0]  hdr_proto;
  logic [31:0] hdr_src;
  logic [31:0] hdr_dst;

  function automatic void clear_packet_state();
    rx_count    = '0;
    hdr_version = '0;
    hdr_len     = '0;
    csum_acc    = '0;
    hi_hold     = '0;
    tot_len     = '0;
    hdr_ttl     = '0;
    hdr_proto   = '0;
    hdr_src     = '0;
    hdr_dst     = '0;
  endfunction

  function automatic void track_header_byte(input logic [7:0] b, input logic last);
    logic [15:0]   idx;
    logic [16:0]   s;
    logic [15:0]   len;
    logic [15:0]   tl;
    verdict_item_t e;
    idx = rx_count;
    if (idx == 0) begin
      hdr_version = b[7:4];
      hdr_len     = {b[3:0] & NIBBLE_MASK, 2'b00};
    end
    if (idx == 2) tot_len[15:8] = b;
    if (idx == 3) tot_len[7:0] = b;
    if (idx == 8) hdr_ttl = b;
    if (idx == 9) hdr_proto = b;
    if (idx >= 12 && idx <= 15) hdr_src = {hdr_src[23:0], b};
    if (idx >= 16 && idx <= 19) hdr_dst = {hdr_dst[23:0], b};
    if (idx < {10'd0, hdr_len}) begin
      if (!idx[0]) begin
        hi_hold = b;
      end else begin
        // ones' complement add with end-around carry
        s        = {1'b0, csum_acc} + {1'b0, hi_hold, b};
        csum_acc = s[15:0] + {15'd0, s[16]};
      end
    end
    if (rx_count != COUNT_MAX) rx_count = rx_count + 16'd1;
    if (!last) return;

    len = rx_count;
    e   = '0;
    if (len < {10'd0, MIN_HDR}) begin
      e.verdict = VERDICT_TOO_SHORT;
    end else if (hdr_version != IP_VERSION || hdr_len < MIN_HDR ||
                 len < {10'd0, hdr_len}) begin
      e.verdict = VERDICT_BAD_HEADER;
    end else if (csum_acc != SUM_GOOD) begin
      e.verdict = VERDICT_BAD_SUM;
    end else if (filter_on_q && hdr_dst != own_addr_q && hdr_dst != BROADCAST &&
                 hdr_dst[31:24] != LOOPBACK_NET) begin
      e.verdict = VERDICT_NOT_OURS;
    end else begin
      if (hdr_proto == PROTO_ICMP) e.verdict = VERDICT_ICMP;
      else if (hdr_proto == PROTO_UDP) e.verdict = VERDICT_UDP;
      else e.verdict = VERDICT_OTHER;
      tl       = (tot_len > len) ? len : tot_len;
      e.src    = hdr_src;
      e.ttl    = hdr_ttl;
      e.proto  = hdr_proto;
      e.hbytes = hdr_len;
      e.plen   = (tl > {10'd0, hdr_len}) ? tl - {10'd0, hdr_len} : 16'd0;
    end
    verdict_expected.push_back(e);
    clear_packet_state();
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_result
    verdict_item_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (verdict_expected.size() == 0) begin
        report_mismatch("unexpected verdict item", 32'(res_ch.verdict), '0);
      end else begin
        want = verdict_expected.pop_front();
        if (res_ch.verdict !== want.verdict)
          report_mismatch("verdict", 32'(res_ch.verdict), 32'(want.verdict));
        if (res_ch.source_address !== want.src)
          report_mismatch("source_address", res_ch.source_address, want.src);
        if (res_ch.time_to_live !== want.ttl)
          report_mismatch("time_to_live", 32'(res_ch.time_to_live), 32'(want.ttl));
        if (res_ch.protocol_number !== want.proto)
          report_mismatch("protocol_number", 32'(res_ch.protocol_number), 32'(want.proto));
        if (res_ch.header_bytes !== want.hbytes)
          report_mismatch("header_bytes", 32'(res_ch.header_bytes), 32'(want.hbytes));
        if (res_ch.payload_length !== want.plen)
          report_mismatch("payload_length", 32'(res_ch.payload_length), 32'(want.plen));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid     <= 1'b1;
    rx_ch.pkt_byte  <= b;
    rx_ch.last_byte <= last;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    track_header_byte(b, last);
    bytes_sent++;
  endtask

  // builds a header with options and payload, optionally spoils the checksum or cuts the tail
  task automatic send_spec(input header_spec_t h, input int unsigned pay_len,
                           input logic [15:0] sum_flip, input int unsigned keep);
    logic [7:0]  pkt[$];
    int unsigned hl;
    int unsigned opt_end;
    int unsigned n;
    int unsigned i;
    logic [16:0] acc;
    logic [15:0] csum;
    logic [15:0] tot;
    hl      = h.ihl * 4;
    opt_end = (hl > 20) ? hl : 20;
    pkt     = {};
    pkt.push_back({h.ver, h.ihl});
    pkt.push_back(8'($urandom));
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    for (i = 0; i < 4; i++) pkt.push_back(8'($urandom));
    pkt.push_back(h.ttl);
    pkt.push_back(h.proto);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    for (i = 0; i < 4; i++) pkt.push_back(h.src[31-8*i -: 8]);
    for (i = 0; i < 4; i++) pkt.push_back(h.dst[31-8*i -: 8]);
    while (pkt.size() < opt_end) pkt.push_back(8'($urandom));
    for (i = 0; i < pay_len; i++) pkt.push_back(8'($urandom));
    tot    = h.auto_len ? 16'(opt_end + pay_len) : h.tot;
    pkt[2] = tot[15:8];
    pkt[3] = tot[7:0];
    acc    = '0;
    for (i = 0; i + 1 < hl; i += 2) begin
      acc = {1'b0, acc[15:0]} + {1'b0, pkt[i], pkt[i+1]};
      acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
    end
    csum    = ~acc[15:0] ^ sum_flip;
    pkt[10] = csum[15:8];
    pkt[11] = csum[7:0];
    n = (keep != 0 && keep < pkt.size()) ? keep : pkt.size();
    for (i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
  endtask

  function automatic header_spec_t good_spec(input logic [7:0] proto, input logic [31:0] dst);
    header_spec_t h;
    h.ver      = IP_VERSION;
    h.ihl      = 4'd5;
    h.tot      = '0;
    h.auto_len = 1'b1;
    h.ttl      = 8'($urandom);
    h.proto    = proto;
    h.src      = $urandom;
    h.dst      = dst;
    return h;
  endfunction

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (verdict_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx == CFG_OWN_ADDRESS) own_addr_q = data;
    else filter_on_q = data[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] addr, input logic present);
    wait_idle();
    write_reg(CFG_OWN_ADDRESS, addr);
    // upper data bits are don't-care for the one-bit register
    write_reg(CFG_INTERFACE_PRESENT, ($urandom & 32'hFFFF_FFFE) | 32'(present));
  endtask

  function automatic logic [31:0] pick_destination();
    case ($urandom_range(4))
      0:       return own_addr_q;
      1:       return BROADCAST;
      2:       return {LOOPBACK_NET, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_protocol();
    case ($urandom_range(2))
      0:       return PROTO_ICMP;
      1:       return PROTO_UDP;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic test_reset_config();
    header_spec_t h;
    // own address 0 and filter on straight out of reset
    h = good_spec(PROTO_ICMP, 32'h0000_0000);
    send_spec(h, 4, '0, 0);
    h = good_spec(PROTO_UDP, 32'h0102_0304);
    send_spec(h, 4, '0, 0);
  endtask

  task automatic test_protocols();
    header_spec_t h;
    set_config(32'hC0A8_0A01, 1'b1);
    h     = good_spec(PROTO_ICMP, own_addr_q);
    h.ttl = 8'h00;
    h.src = 32'h0000_0000;
    send_spec(h, 8, '0, 0);
    h     = good_spec(PROTO_UDP, BROADCAST);
    h.ttl = 8'hFF;
    h.src = 32'hFFFF_FFFF;
    send_spec(h, 12, '0, 0);
    h = good_spec(8'h00, {LOOPBACK_NET, 24'h000001});
    send_spec(h, 3, '0, 0);
    h = good_spec(8'hFF, own_addr_q);
    send_spec(h, 0, '0, 0);
    h = good_spec(8'd6, own_addr_q);
    send_spec(h, 5, '0, 0);
  endtask

  task automatic test_destination_filter();
    header_spec_t h;
    h = good_spec(PROTO_UDP, 32'h7EFF_FFFF);
    send_spec(h, 2, '0, 0);
    h = good_spec(PROTO_UDP, 32'h8000_0000);
    send_spec(h, 2, '0, 0);
    h = good_spec(PROTO_UDP, 32'h7FFF_FFFF);
    send_spec(h, 2, '0, 0);
    h = good_spec(PROTO_ICMP, own_addr_q ^ 32'h1);
    send_spec(h, 2, '0, 0);
    set_config(32'hFFFF_FFFF, 1'b1);
    h = good_spec(PROTO_ICMP, 32'hFFFF_FFFE);
    send_spec(h, 2, '0, 0);
    h = good_spec(PROTO_ICMP, 32'hFFFF_FFFF);
    send_spec(h, 2, '0, 0);
    // filter off accepts anything
    set_config(32'h0A00_0001, 1'b0);
    h = good_spec(PROTO_UDP, $urandom);
    send_spec(h, 6, '0, 0);
    h = good_spec(8'd6, 32'h0000_0000);
    send_spec(h, 6, '0, 0);
    set_config(32'hC0A8_0A01, 1'b1);
  endtask

  task automatic test_header_errors();
    header_spec_t h;
    h     = good_spec(PROTO_UDP, own_addr_q);
    h.ver = 4'd6;
    send_spec(h, 4, '0, 0);
    h.ver = 4'd0;
    send_spec(h, 4, '0, 0);
    h.ver = 4'hF;
    send_spec(h, 4, '0, 0);
    h     = good_spec(PROTO_UDP, own_addr_q);
    h.ihl = 4'd4;
    send_spec(h, 4, '0, 0);
    h.ihl = 4'd0;
    send_spec(h, 4, '0, 0);
    // header ends before ihl says it should
    h.ihl = 4'hF;
    send_spec(h, 0, '0, 40);
    h = good_spec(PROTO_ICMP, own_addr_q);
    send_spec(h, 4, 16'h0001, 0);
    send_spec(h, 4, 16'hFFFF, 0);
    // checksum is checked before the destination
    h = good_spec(PROTO_ICMP, own_addr_q ^ 32'h100);
    send_spec(h, 4, 16'h8000, 0);
    // length is checked before the version
    h     = good_spec(PROTO_ICMP, own_addr_q);
    h.ver = 4'd6;
    send_spec(h, 0, '0, 10);
  endtask

  task automatic test_short_packets();
    header_spec_t h;
    h     = good_spec(PROTO_ICMP, own_addr_q);
    h.ver = 4'hF;
    h.ihl = 4'hF;
    send_spec(h, 0, '0, 1);
    send_byte(8'h00, 1'b1);
    h = good_spec(PROTO_ICMP, own_addr_q);
    send_spec(h, 0, '0, 19);
    send_spec(h, 0, '0, 20);
  endtask

  task automatic test_length_fields();
    header_spec_t h;
    // total length below the header length gives no payload
    h          = good_spec(PROTO_UDP, own_addr_q);
    h.auto_len = 1'b0;
    h.tot      = 16'd10;
    send_spec(h, 6, '0, 0);
    h.tot = 16'h0000;
    send_spec(h, 6, '0, 0);
    // total length above what arrived is clamped, one within it is used as given
    h.tot = 16'hFFFF;
    send_spec(h, 10, '0, 0);
    h.tot = 16'd27;
    send_spec(h, 10, '0, 0);
    h     = good_spec(PROTO_ICMP, own_addr_q);
    h.ihl = 4'hF;
    send_spec(h, 0, '0, 0);
  endtask

  task automatic test_random_traffic(input int unsigned budget);
    header_spec_t h;
    int unsigned  start;
    int unsigned  chunk_start;
    int unsigned  roll;
    int unsigned  pay;
    int unsigned  keep;
    int unsigned  n;
    int unsigned  i;
    logic [15:0]  flip;
    logic [31:0]  addr;
    start       = bytes_sent;
    chunk_start = bytes_sent;
    while (bytes_sent - start < budget) begin
      if (bytes_sent - chunk_start >= CHUNK_BYTES) begin
        case ($urandom_range(3))
          0:       addr = 32'h0000_0000;
          1:       addr = 32'hFFFF_FFFF;
          2:       addr = {LOOPBACK_NET, 24'($urandom)};
          default: addr = $urandom;
        endcase
        set_config(addr, 1'($urandom));
        chunk_start = bytes_sent;
      end
      roll = $urandom_range(99);
      h    = good_spec(pick_protocol(), pick_destination());
      pay  = $urandom_range(24);
      flip = '0;
      keep = 0;
      if ($urandom_range(3) == 0) h.ihl = 4'($urandom_range(15, 6));
      if ($urandom_range(6) == 0) begin
        h.auto_len = 1'b0;
        h.tot      = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(80));
      end
      if (roll < 70) begin
        send_spec(h, pay, flip, keep);
      end else if (roll < 88) begin
        case ($urandom_range(3))
          0:       flip = 16'($urandom_range(16'hFFFF, 1));
          1:       h.ver = 4'($urandom);
          2:       h.ihl = 4'($urandom_range(4));
          default: keep = $urandom_range(60, 1);
        endcase
        send_spec(h, pay, flip, keep);
      end else begin
        n = $urandom_range(30, 1);
        for (i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
      end
    end
  endtask

  initial begin
    rx_ch.valid     = 1'b0;
    rx_ch.pkt_byte  = '0;
    rx_ch.last_byte = 1'b0;
    res_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_OWN_ADDRESS;
    cfg_data        = '0;
    mismatches      = 0;
    bytes_sent      = 0;
    src_idle_pct    = 31;
    sink_idle_pct   = 47;
    own_addr_q      = '0;
    filter_on_q     = 1'b1;
    clear_packet_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_config();
    test_protocols();
    test_destination_filter();
    test_header_errors();
    test_short_packets();
    test_length_fields();
    test_random_traffic(RANDOM_BUDGET);

    wait_idle();
    src_idle_pct  = 47;
    sink_idle_pct = 31;
    set_config($urandom, 1'b1);
    test_random_traffic(RANDOM_BUDGET);

    wait_idle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(32'h0000_0000, 1'b0);
    test_random_traffic(RANDOM_BUDGET);

    wait_idle();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ihc_pkg.sv
hw/rtl/ihc_channels.sv
hw/rtl/ihc_front.sv
hw/rtl/ihc_queue.sv
hw/rtl/ihc_back.sv
hw/rtl/ipv4_receive_header_check.sv
verif/ipv4_receive_header_check_tb.sv
